[design/rstmp_pkg.sv]
package rstmp_pkg;

	// Register map and widths
	localparam int JL_W = 42;
	localparam int CLK_W = 64;
	localparam logic [JL_W-1:0] JUMP_LIMIT_RST = 42'd270000000;
	localparam logic REG_JUMP_LIMIT = 1'b0;
	localparam logic REG_STRIP = 1'b1;

	// Start codes and video codes to strip
	localparam logic [31:0] SC_PACK = 32'h000001BA;
	localparam logic [31:0] SC_SYS = 32'h000001BB;
	localparam logic [31:0] SC_AUDIO = 32'h000001C0;
	localparam logic [31:0] SC_VIDEO = 32'h000001E0;
	localparam logic [7:0] CODE_SEQ_END = 8'hB7;
	localparam logic [7:0] CODE_GOP = 8'hB8;
	localparam logic [7:0] CODE_STOP = 8'hB9;
	localparam logic [7:0] ID_VIDEO = 8'hE0;

	typedef enum logic [2:0] {
		PH_SEARCH,
		PH_SYS,
		PH_PACK,
		PH_LEN,
		PH_HDR,
		PH_XHDR,
		PH_PAY
	} phase_t;

	typedef enum logic [2:0] {
		MD_IDLE,
		MD_HOLD,
		MD_TAIL,
		MD_PACK_CHK,
		MD_PACK_ACC,
		MD_PACK_PUT,
		MD_PES_PUT
	} mode_t;

	typedef struct packed {
		logic [JL_W-1:0] jump_limit;
		logic strip_enable;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic [7:0] data;
		logic last;
	} emit_t;

endpackage

[design/mpeg_ps_timestamp_restamper_top.sv]
// Channel   Handshake              Payload
// input     in_valid / in_ready    in_byte
// output    out_valid / out_ready  out_byte, run_last
// config    psel/penable/pready    pwrite, paddr, pwdata, prdata
//
// Payload and search bytes are taken one per cycle unless a burst, or a byte held by
// a full 2-entry output queue, holds input off. A pack header runs the clock states
// check, accumulate and put, then a 12 or 14 byte burst from the hold buffer; a PES
// header runs the timestamp put state, then a burst of 9 to 25 bytes. Bursts read the
// hold buffer one byte per cycle while the queue has room, which sets the header rate.
// Reset clears all control state; the hold buffer is written before it is read.
module mpeg_ps_timestamp_restamper_top (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] in_byte,
	output logic out_valid,
	input  logic out_ready,
	output logic [7:0] out_byte,
	output logic run_last,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [3:0] paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready
);

	rstmp_pkg::cfg_t cfg;
	rstmp_pkg::emit_t emit;
	logic oq_full;

	rstmp_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	rstmp_core u_core (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .in_valid(in_valid), .in_ready(in_ready),
		.in_byte(in_byte), .oq_full(oq_full), .emit(emit)
	);

	rstmp_oq u_oq (
		.clk(clk), .arst_n(arst_n), .push(emit), .full(oq_full), .out_valid(out_valid),
		.out_ready(out_ready), .out_byte(out_byte), .run_last(run_last)
	);

endmodule

[design/rstmp_cfg.sv]
module rstmp_cfg (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [3:0] paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready,
	output rstmp_pkg::cfg_t cfg
);

	logic [rstmp_pkg::JL_W-1:0] jump_limit_q;
	logic strip_q;
	logic wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	// Write registers on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jump_limit_q <= rstmp_pkg::JUMP_LIMIT_RST;
			strip_q <= 1'b1;
		end else if (wr) begin
			if (paddr[3] == rstmp_pkg::REG_JUMP_LIMIT) jump_limit_q <= pwdata[rstmp_pkg::JL_W-1:0];
			else strip_q <= pwdata[0];
		end
	end

	// Read back
	always_comb begin
		if (paddr[3] == rstmp_pkg::REG_STRIP) prdata = {63'd0, strip_q};
		else prdata = {{(64-rstmp_pkg::JL_W){1'b0}}, jump_limit_q};
	end

	assign cfg.jump_limit = jump_limit_q;
	assign cfg.strip_enable = strip_q;

endmodule

[design/rstmp_oq.sv]
module rstmp_oq (
	input  logic clk,
	input  logic arst_n,
	input  rstmp_pkg::emit_t push,
	output logic full,
	output logic out_valid,
	input  logic out_ready,
	output logic [7:0] out_byte,
	output logic run_last
);

	logic [8:0] mem_q [2];
	logic wptr_q, rptr_q;
	logic [1:0] cnt_q;
	logic pop;

	assign full = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign pop = out_valid && out_ready;
	assign out_byte = mem_q[rptr_q][8:1];
	assign run_last = mem_q[rptr_q][0];

	// Store pushed bytes
	always_ff @(posedge clk) begin
		if (push.valid) mem_q[wptr_q] <= {push.data, push.last};
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push.valid) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			if (push.valid && !pop) cnt_q <= cnt_q + 2'd1;
			else if (!push.valid && pop) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

[design/rstmp_core.sv]
module rstmp_core (
	input  logic clk,
	input  logic arst_n,
	input  rstmp_pkg::cfg_t cfg,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] in_byte,
	input  logic oq_full,
	output rstmp_pkg::emit_t emit
);

	// 5-byte timestamp field (MPEG-1 SCR, PTS, DTS)
	function automatic logic [41:0] ts_get(input logic [39:0] h);
		return {h[35:33], h[31:24], h[23:17], h[15:8], h[7:1], 9'd0};
	endfunction

	function automatic logic [39:0] ts_put(input logic [39:0] h, input logic [41:0] v);
		return {h[39:36], v[41:39], h[32], v[38:31], v[30:24], h[16], v[23:16],
			v[15:9], h[0]};
	endfunction

	// 6-byte clock field (MPEG-2 SCR, ESCR)
	function automatic logic [41:0] scr_get(input logic [47:0] h);
		return {h[45:43], h[41:40], h[39:32], h[31:27], h[25:24], h[23:16],
			h[15:11], h[9:8], h[7:1]};
	endfunction

	function automatic logic [47:0] scr_put(input logic [47:0] h, input logic [41:0] v);
		return {h[47:46], v[41:39], h[42], v[38:37], v[36:29], v[28:24], h[26],
			v[23:22], v[21:14], v[13:9], h[10], v[8:7], v[6:0], h[0]};
	endfunction

	function automatic logic ts_mk(input logic [39:0] h);
		return h[32] & h[16] & h[0];
	endfunction

	function automatic logic scr_mk(input logic [47:0] h);
		return h[42] & h[26] & h[10] & h[0];
	endfunction

	function automatic logic [4:0] ts_len(input logic [7:0] f);
		return (f[7] ? 5'd5 : 5'd0) + ((f[7:6] == 2'b11) ? 5'd5 : 5'd0) + (f[5] ? 5'd6 : 5'd0);
	endfunction

	// State
	logic [7:0] hold_q [32];
	logic [31:0] sync_q;
	rstmp_pkg::phase_t phase_q;
	logic [15:0] fc_q, pl_q;
	logic [23:0] sw_q;
	logic sent_q;
	rstmp_pkg::mode_t mode_q;
	logic [4:0] cnt_q, len_q, need_q;
	logic [7:0] tail_q [4];
	logic [41:0] prev_scr_q, prev_step_q, scr_q, delta_q;
	logic [63:0] oc_q, off_q;

	logic [255:0] hv;
	logic acc;

	// Step results
	logic [31:0] st_sync;
	rstmp_pkg::phase_t st_phase;
	logic [15:0] st_fc, st_pl;
	logic [23:0] st_sw;
	logic st_sent, st_wr_en, st_start;
	logic [4:0] st_wr_idx, st_len, st_need;
	logic [7:0] st_code;
	rstmp_pkg::mode_t st_mode;
	logic [7:0] st_tail [4];

	// Search path
	logic [31:0] s_win;
	logic s_start;
	logic [7:0] s_code;
	rstmp_pkg::phase_t s_phase;

	// Pack check
	logic pk_mpeg2, pk_ok, pk_bad;
	logic [41:0] pk_scr, pk_diff;
	logic [42:0] pk_sum;

	// PES restamp
	logic [7:0] pe_f;
	logic pe_hp, pe_hd, pe_he, pe_ok;
	logic [1:0] pe_esel;
	logic [47:0] pe_ewin, pe_eput;
	logic [39:0] pe_pput, pe_dput;
	logic [4:0] pe_tl;
	logic [7:0] pe_fc;
	rstmp_pkg::phase_t pe_phase;

	// Flatten the hold buffer for fixed windows
	always_comb begin
		for (int i = 0; i < 32; i++) hv[255-8*i -: 8] = hold_q[i];
	end

	// Emission from hold buffer or tail list
	always_comb begin
		emit.valid = ((mode_q == rstmp_pkg::MD_HOLD) || (mode_q == rstmp_pkg::MD_TAIL)) && !oq_full;
		emit.data = (mode_q == rstmp_pkg::MD_TAIL) ? tail_q[cnt_q[1:0]] : hold_q[cnt_q];
		emit.last = (cnt_q == len_q - 5'd1);
	end

	assign in_ready = (mode_q == rstmp_pkg::MD_IDLE) || (emit.valid && emit.last);
	assign acc = in_valid && in_ready;

	// Start code search
	always_comb begin
		s_win = {sync_q[23:0], in_byte};
		s_start = 1'b0;
		s_phase = rstmp_pkg::PH_SEARCH;
		s_code = s_win[7:0];
		if (s_win == rstmp_pkg::SC_PACK) begin
			s_start = 1'b1;
			s_phase = rstmp_pkg::PH_PACK;
		end else if (s_win == rstmp_pkg::SC_SYS) begin
			if (!sent_q) begin
				s_start = 1'b1;
				s_phase = rstmp_pkg::PH_SYS;
			end
		end else if (s_win == rstmp_pkg::SC_AUDIO || s_win == rstmp_pkg::SC_VIDEO) begin
			s_start = 1'b1;
			s_phase = rstmp_pkg::PH_LEN;
		end
	end

	// One input byte
	always_comb begin
		logic [7:0] t [4];
		logic [2:0] n;
		logic [23:0] w;
		logic [15:0] f;
		logic [7:0] bb, h4, fb;
		logic [1:0] pend;
		logic [4:0] need;
		logic [16:0] idx;
		logic [15:0] fc_inc, pl_dec;
		logic strip;
		for (int k = 0; k < 4; k++) t[k] = 8'd0;
		n = 3'd0;
		w = sw_q;
		f = fc_q;
		bb = in_byte;
		h4 = hold_q[4];
		fb = hold_q[7];
		pend = 2'd0;
		need = 5'd3;
		idx = 17'd6 + {1'b0, fc_q};
		fc_inc = fc_q + 16'd1;
		pl_dec = pl_q - 16'd1;
		strip = (hold_q[3] == rstmp_pkg::ID_VIDEO) && cfg.strip_enable;

		st_sync = sync_q;
		st_phase = phase_q;
		st_fc = fc_q;
		st_pl = pl_q;
		st_sw = sw_q;
		st_sent = sent_q;
		st_wr_en = 1'b0;
		st_wr_idx = 5'd4 + fc_q[4:0];
		st_start = 1'b0;
		st_code = s_code;
		st_mode = rstmp_pkg::MD_IDLE;
		st_len = 5'd0;
		st_need = need_q;

		unique case (phase_q)
			rstmp_pkg::PH_SYS: begin
				st_wr_en = 1'b1;
				st_fc = fc_inc;
				if (fc_inc >= 16'd8) begin
					st_mode = rstmp_pkg::MD_HOLD;
					st_len = 5'd12;
					st_sent = 1'b1;
					st_phase = rstmp_pkg::PH_SEARCH;
				end
			end
			rstmp_pkg::PH_PACK: begin
				if (fc_q == 16'd0 && in_byte[7:6] != 2'b01 && in_byte[7:4] != 4'h2) begin
					st_sync = s_win;
					st_phase = s_phase;
					st_start = s_start;
					st_fc = 16'd0;
				end else begin
					st_wr_en = 1'b1;
					st_fc = fc_inc;
					if (fc_q == 16'd0) h4 = in_byte;
					need = (h4[7:6] == 2'b01) ? 5'd10 : 5'd8;
					if (fc_inc >= {11'd0, need}) begin
						st_mode = rstmp_pkg::MD_PACK_CHK;
						st_need = need;
						st_phase = rstmp_pkg::PH_SEARCH;
					end
				end
			end
			rstmp_pkg::PH_LEN: begin
				st_wr_en = 1'b1;
				st_fc = fc_inc;
				if (fc_inc >= 16'd2) begin
					st_pl = {hold_q[4], in_byte};
					st_fc = 16'd0;
					st_phase = ({hold_q[4], in_byte} == 16'd0) ? rstmp_pkg::PH_SEARCH
						: rstmp_pkg::PH_HDR;
				end
			end
			rstmp_pkg::PH_HDR: begin
				if (idx >= 17'd32) begin
					st_phase = rstmp_pkg::PH_SEARCH;
				end else begin
					st_wr_en = 1'b1;
					st_wr_idx = idx[4:0];
					st_fc = fc_inc;
					st_pl = pl_dec;
					if (fc_inc == 16'd1 && in_byte[7:6] != 2'b10) begin
						st_phase = rstmp_pkg::PH_SEARCH;
					end else begin
						if (fc_inc == 16'd2) fb = in_byte;
						need = (fc_inc >= 16'd2) ? 5'd3 + ts_len(fb) : 5'd3;
						if (fc_inc < {11'd0, need}) begin
							if (pl_dec == 16'd0) st_phase = rstmp_pkg::PH_SEARCH;
						end else begin
							st_mode = rstmp_pkg::MD_PES_PUT;
							st_need = need;
						end
					end
				end
			end
			rstmp_pkg::PH_XHDR: begin
				t[0] = in_byte;
				st_mode = rstmp_pkg::MD_TAIL;
				st_len = 5'd1;
				st_pl = pl_dec;
				st_fc = (fc_q > 16'd0) ? fc_q - 16'd1 : 16'd0;
				if (pl_dec == 16'd0) begin
					st_phase = rstmp_pkg::PH_SEARCH;
				end else if (st_fc == 16'd0) begin
					st_sw = 24'd0;
					st_phase = rstmp_pkg::PH_PAY;
				end
			end
			rstmp_pkg::PH_PAY: begin
				if (!strip) begin
					// flush held bytes, then pass the byte
					pend = (f > 16'd3) ? 2'd3 : f[1:0];
					for (int k = 2; k >= 0; k--) begin
						if (k < pend) begin
							t[n[1:0]] = w[8*k +: 8];
							n = n + 3'd1;
						end
					end
					f = 16'd0;
					w = 24'd0;
					t[n[1:0]] = in_byte;
					n = n + 3'd1;
				end else if (f >= 16'd3) begin
					if (w == 24'h000001 && (in_byte == rstmp_pkg::CODE_SEQ_END
						|| in_byte == rstmp_pkg::CODE_GOP || in_byte == rstmp_pkg::CODE_STOP)) begin
						w = 24'd0;
						bb = 8'd0;
					end
					t[n[1:0]] = w[23:16];
					n = n + 3'd1;
					w = {w[15:0], bb};
				end else begin
					w = {w[15:0], in_byte};
					f = f + 16'd1;
				end
				st_pl = pl_dec;
				if (pl_dec == 16'd0) begin
					// packet end: flush the window
					pend = (f > 16'd3) ? 2'd3 : f[1:0];
					for (int k = 2; k >= 0; k--) begin
						if (k < pend) begin
							t[n[1:0]] = w[8*k +: 8];
							n = n + 3'd1;
						end
					end
					f = 16'd0;
					w = 24'd0;
					st_phase = rstmp_pkg::PH_SEARCH;
				end
				st_fc = f;
				st_sw = w;
				if (n != 3'd0) begin
					st_mode = rstmp_pkg::MD_TAIL;
					st_len = {2'd0, n};
				end
			end
			default: begin
				st_sync = s_win;
				st_phase = s_phase;
				st_start = s_start;
				if (s_start) st_fc = 16'd0;
			end
		endcase
		st_tail = t;
	end

	// Pack header check and clock step
	always_comb begin
		pk_mpeg2 = (need_q == 5'd10);
		if (pk_mpeg2) begin
			pk_ok = scr_mk(hv[255-8*4 -: 48]) && (hold_q[12][1:0] == 2'b11);
			pk_scr = scr_get(hv[255-8*4 -: 48]);
		end else begin
			pk_ok = ts_mk(hv[255-8*4 -: 40]) && hold_q[9][7] && hold_q[11][0];
			pk_scr = ts_get(hv[255-8*4 -: 40]);
		end
		pk_sum = {1'b0, prev_scr_q} + {1'b0, cfg.jump_limit};
		pk_bad = (pk_scr < prev_scr_q) || ({1'b0, pk_scr} > pk_sum);
		pk_diff = pk_scr - prev_scr_q;
	end

	// PES timestamp check and shift
	always_comb begin
		pe_f = hold_q[7];
		pe_hp = pe_f[7];
		pe_hd = (pe_f[7:6] == 2'b11);
		pe_he = pe_f[5];
		pe_esel = {1'b0, pe_hp} + {1'b0, pe_hd};
		unique case (pe_esel)
			2'd0: pe_ewin = hv[255-8*9 -: 48];
			2'd1: pe_ewin = hv[255-8*14 -: 48];
			default: pe_ewin = hv[255-8*19 -: 48];
		endcase
		pe_ok = (!pe_hp || (hold_q[9][7:4] == {2'b00, pe_f[7:6]} && ts_mk(hv[255-8*9 -: 40])))
			&& (!pe_hd || (hold_q[14][7:4] == 4'h1 && ts_mk(hv[255-8*14 -: 40])))
			&& (!pe_he || scr_mk(pe_ewin));
		pe_pput = ts_put(hv[255-8*9 -: 40], ts_get(hv[255-8*9 -: 40]) + off_q[41:0]);
		pe_dput = ts_put(hv[255-8*14 -: 40], ts_get(hv[255-8*14 -: 40]) + off_q[41:0]);
		pe_eput = scr_put(pe_ewin, scr_get(pe_ewin) + off_q[41:0]);
		pe_tl = need_q - 5'd3;
		pe_fc = (hold_q[8] > {3'd0, pe_tl}) ? hold_q[8] - {3'd0, pe_tl} : 8'd0;
		if (pl_q == 16'd0) pe_phase = rstmp_pkg::PH_SEARCH;
		else if (pe_fc == 8'd0) pe_phase = rstmp_pkg::PH_PAY;
		else pe_phase = rstmp_pkg::PH_XHDR;
	end

	// Hold buffer writes
	always_ff @(posedge clk) begin
		if (acc) begin
			if (st_start) begin
				hold_q[0] <= 8'h00;
				hold_q[1] <= 8'h00;
				hold_q[2] <= 8'h01;
				hold_q[3] <= st_code;
			end
			if (st_wr_en) hold_q[st_wr_idx] <= in_byte;
		end else if (mode_q == rstmp_pkg::MD_PACK_PUT) begin
			if (pk_mpeg2) begin
				for (int k = 0; k < 6; k++)
					hold_q[4+k] <= scr_put(hv[255-8*4 -: 48], oc_q[41:0])[47-8*k -: 8];
			end else begin
				for (int k = 0; k < 5; k++)
					hold_q[4+k] <= ts_put(hv[255-8*4 -: 40], oc_q[41:0])[39-8*k -: 8];
			end
		end else if (mode_q == rstmp_pkg::MD_PES_PUT && pe_ok) begin
			if (pe_hp) for (int k = 0; k < 5; k++) hold_q[9+k] <= pe_pput[39-8*k -: 8];
			if (pe_hd) for (int k = 0; k < 5; k++) hold_q[14+k] <= pe_dput[39-8*k -: 8];
			if (pe_he) begin
				unique case (pe_esel)
					2'd0: for (int k = 0; k < 6; k++) hold_q[9+k] <= pe_eput[47-8*k -: 8];
					2'd1: for (int k = 0; k < 6; k++) hold_q[14+k] <= pe_eput[47-8*k -: 8];
					default: for (int k = 0; k < 6; k++) hold_q[19+k] <= pe_eput[47-8*k -: 8];
				endcase
			end
		end
	end

	// Parser state and post-processing sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= 32'd0;
			phase_q <= rstmp_pkg::PH_SEARCH;
			fc_q <= 16'd0;
			pl_q <= 16'd0;
			sw_q <= 24'd0;
			sent_q <= 1'b0;
			mode_q <= rstmp_pkg::MD_IDLE;
			cnt_q <= 5'd0;
			len_q <= 5'd0;
			need_q <= 5'd0;
			for (int k = 0; k < 4; k++) tail_q[k] <= 8'd0;
			prev_scr_q <= 42'd0;
			prev_step_q <= 42'd0;
			scr_q <= 42'd0;
			delta_q <= 42'd0;
			oc_q <= 64'd0;
			off_q <= 64'd0;
		end else if (acc) begin
			sync_q <= st_sync;
			phase_q <= st_phase;
			fc_q <= st_fc;
			pl_q <= st_pl;
			sw_q <= st_sw;
			sent_q <= st_sent;
			mode_q <= st_mode;
			cnt_q <= 5'd0;
			len_q <= st_len;
			need_q <= st_need;
			tail_q <= st_tail;
		end else begin
			unique case (mode_q)
				rstmp_pkg::MD_HOLD, rstmp_pkg::MD_TAIL: begin
					if (emit.valid) begin
						cnt_q <= cnt_q + 5'd1;
						if (emit.last) mode_q <= rstmp_pkg::MD_IDLE;
					end
				end
				rstmp_pkg::MD_PACK_CHK: begin
					if (pk_ok) begin
						scr_q <= pk_scr;
						delta_q <= pk_bad ? prev_step_q : pk_diff;
						if (!pk_bad) prev_step_q <= pk_diff;
						mode_q <= rstmp_pkg::MD_PACK_ACC;
					end else begin
						mode_q <= rstmp_pkg::MD_IDLE;
					end
				end
				rstmp_pkg::MD_PACK_ACC: begin
					oc_q <= oc_q + {22'd0, delta_q};
					prev_scr_q <= scr_q;
					mode_q <= rstmp_pkg::MD_PACK_PUT;
				end
				rstmp_pkg::MD_PACK_PUT: begin
					off_q <= oc_q - {22'd0, scr_q};
					mode_q <= rstmp_pkg::MD_HOLD;
					cnt_q <= 5'd0;
					len_q <= need_q + 5'd4;
				end
				rstmp_pkg::MD_PES_PUT: begin
					if (pe_ok) begin
						fc_q <= {8'd0, pe_fc};
						sw_q <= 24'd0;
						phase_q <= pe_phase;
						mode_q <= rstmp_pkg::MD_HOLD;
						cnt_q <= 5'd0;
						len_q <= need_q + 5'd6;
					end else begin
						phase_q <= rstmp_pkg::PH_SEARCH;
						mode_q <= rstmp_pkg::MD_IDLE;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

[design/rstmp_chk.sv]
module rstmp_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic [7:0] in_byte,
	input logic out_valid,
	input logic out_ready,
	input logic [7:0] out_byte,
	input logic run_last,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [63:0] pwdata,
	input logic [63:0] prdata,
	input logic pready
);

	// A stalled output transaction holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last))
		else $error("output transaction changed while stalled");

	// The config port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

	// Nothing is offered right after reset
	a_rst_empty: assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
		else $error("output valid out of reset");

	// A written jump limit reads back
	a_jl_rb: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && !paddr[3] |=>
		paddr[3] || prdata[41:0] == $past(pwdata[41:0]))
		else $error("jump limit readback mismatch");

	// A written strip enable reads back
	a_strip_rb: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr[3] |=>
		!paddr[3] || prdata[0] == $past(pwdata[0]))
		else $error("strip enable readback mismatch");

endmodule

bind mpeg_ps_timestamp_restamper_top rstmp_chk u_chk (.*);
